// ===== rtl/core/wfba_pkg.sv =====
// wfba_pkg: shared types and constants for the worst-fit block allocator
// used by wfba_alu, wfba_seq and the allocator unit under rtl/core; depends on nothing

package wfba_pkg;

    localparam int SUM_W           = 20;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam int SLOT_W          = 4;
    localparam int AMOUNT_W        = 16;
    localparam int DEF_NUM_BLOCKS  = 16;
    localparam int DEF_SIZE_BITS   = 16;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_ALLOC = 1'b1;

    typedef enum logic
    {
        OP_ADD,
        OP_SUB
    } wfba_op_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_LD_READ,
        ST_LD_SUB,
        ST_LD_ADD,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_EMIT
    } wfba_state_t;

    typedef struct packed
    {
        logic idle;
        logic accept;
        logic ld_read;
        logic ld_sub;
        logic ld_add;
        logic scan_issue;
        logic scan_cmp;
        logic decide;
        logic emit_go;
    } wfba_ctrl_t;

endpackage

// ===== rtl/core/wfba_ram.sv =====
// wfba_ram: generic single-write, single-read ram with registered read data
// depends on nothing

module wfba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/wfba_alu.sv =====
// wfba_alu: shared saturating add / floored subtract and magnitude compare
// depends on wfba_pkg

module wfba_alu #(
    parameter int SIZE_BITS = wfba_pkg::DEF_SIZE_BITS
) (
    input  wfba_pkg::wfba_op_t           op,
    input  logic [wfba_pkg::SUM_W-1:0]   acc,
    input  logic [SIZE_BITS-1:0]         operand,
    input  logic [SIZE_BITS-1:0]         cmp_a,
    input  logic [SIZE_BITS-1:0]         cmp_b,
    output logic [wfba_pkg::SUM_W-1:0]   result,
    output logic                         greater
);

    localparam int ARITH_W =
        ((SIZE_BITS > wfba_pkg::SUM_W) ? SIZE_BITS : wfba_pkg::SUM_W) + 1;

    logic [ARITH_W-1:0] wide_a;
    logic [ARITH_W-1:0] wide_b;
    logic [ARITH_W-1:0] sum;
    logic [ARITH_W-1:0] diff;

    assign wide_a = ARITH_W'(acc);
    assign wide_b = ARITH_W'(operand);
    assign sum    = wide_a + wide_b;
    assign diff   = wide_a - wide_b;

    always_comb
    begin
        case (op)
            wfba_pkg::OP_ADD:
            begin
                result = (sum > ARITH_W'(wfba_pkg::SUM_MAX)) ? wfba_pkg::SUM_MAX
                                                           : sum[wfba_pkg::SUM_W-1:0];
            end
            wfba_pkg::OP_SUB:
            begin
                // floor at zero
                result = (wide_b >= wide_a) ? '0 : diff[wfba_pkg::SUM_W-1:0];
            end
            default:
            begin
                result = acc;
            end
        endcase
    end

    assign greater = cmp_a > cmp_b;

endmodule

// ===== rtl/core/wfba_seq.sv =====
// wfba_seq: sequencer for loads and worst-fit scans, with the scan counter
// depends on wfba_pkg

module wfba_seq #(
    parameter int NUM_BLOCKS = wfba_pkg::DEF_NUM_BLOCKS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          kind,
    input  logic                          slot_ok,
    input  logic                          out_free,
    output wfba_pkg::wfba_ctrl_t          ctrl,
    output logic [$clog2(NUM_BLOCKS)-1:0] cnt
);

    localparam int IDX_W = $clog2(NUM_BLOCKS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

    wfba_pkg::wfba_state_t state_reg;
    wfba_pkg::wfba_state_t state_next;
    logic [IDX_W-1:0]      cnt_reg;
    logic [IDX_W-1:0]      cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wfba_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            wfba_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                if (req_valid)
                begin
                    if (kind == wfba_pkg::KIND_ALLOC)
                    begin
                        state_next = wfba_pkg::ST_SCAN;
                    end
                    else if (slot_ok)
                    begin
                        state_next = wfba_pkg::ST_LD_READ;
                    end
                    else
                    begin
                        state_next = wfba_pkg::ST_EMIT;
                    end
                end
            end
            wfba_pkg::ST_LD_READ:
            begin
                state_next = wfba_pkg::ST_LD_SUB;
            end
            wfba_pkg::ST_LD_SUB:
            begin
                state_next = wfba_pkg::ST_LD_ADD;
            end
            wfba_pkg::ST_LD_ADD:
            begin
                state_next = wfba_pkg::ST_EMIT;
            end
            wfba_pkg::ST_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = wfba_pkg::ST_DRAIN;
                end
            end
            wfba_pkg::ST_DRAIN:
            begin
                state_next = wfba_pkg::ST_DECIDE;
            end
            wfba_pkg::ST_DECIDE:
            begin
                state_next = wfba_pkg::ST_EMIT;
            end
            wfba_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = wfba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wfba_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            wfba_pkg::ST_IDLE:
            begin
                ctrl.idle   = 1'b1;
                ctrl.accept = req_valid;
            end
            wfba_pkg::ST_LD_READ:
            begin
                ctrl.ld_read = 1'b1;
            end
            wfba_pkg::ST_LD_SUB:
            begin
                ctrl.ld_sub = 1'b1;
            end
            wfba_pkg::ST_LD_ADD:
            begin
                ctrl.ld_add = 1'b1;
            end
            wfba_pkg::ST_SCAN:
            begin
                ctrl.scan_issue = 1'b1;
                ctrl.scan_cmp   = 1'b1;
            end
            wfba_pkg::ST_DRAIN:
            begin
                ctrl.scan_cmp = 1'b1;
            end
            wfba_pkg::ST_DECIDE:
            begin
                ctrl.decide = 1'b1;
            end
            wfba_pkg::ST_EMIT:
            begin
                ctrl.emit_go = out_free;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    assign cnt = cnt_reg;

endmodule

// ===== rtl/core/worst_fit_block_allocator_unit.sv =====
// Worst-fit block allocator. One beat is taken at a time: a load beat reads the old size,
// subtracts it, adds the new one and presents the result before the next beat can be
// accepted, a load to a slot at or beyond NUM_BLOCKS only presents its result, and an
// allocate beat runs a scan that reads one size entry a cycle from the size ram and runs
// it through the shared compare to find the largest free block (lowest index wins a tie).
// The result sits in an output register, so the next beat is accepted while a result
// still waits to be taken. Totals saturate at 2^20 - 1.
// Depends on wfba_pkg, wfba_ram, wfba_alu and wfba_seq.

module worst_fit_block_allocator_unit #(
    parameter int NUM_BLOCKS = wfba_pkg::DEF_NUM_BLOCKS,
    parameter int SIZE_BITS  = wfba_pkg::DEF_SIZE_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic                            kind,
    input  logic [wfba_pkg::SLOT_W-1:0]     slot,
    input  logic [wfba_pkg::AMOUNT_W-1:0]   amount,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic                            granted,
    output logic [wfba_pkg::SLOT_W-1:0]     chosen_slot,
    output logic [wfba_pkg::AMOUNT_W-1:0]   chosen_size,
    output logic [wfba_pkg::SUM_W-1:0]      used_total,
    output logic [wfba_pkg::SUM_W-1:0]      memory_total
);

    localparam int IDX_W = $clog2(NUM_BLOCKS);

    wfba_pkg::wfba_ctrl_t ctrl;
    logic [IDX_W-1:0]     cnt;
    logic                 slot_ok;
    logic                 out_free;

    logic [wfba_pkg::SLOT_W-1:0]   slot_reg;
    logic [SIZE_BITS-1:0]          amount_reg;
    logic [IDX_W-1:0]              slot_idx;

    logic [NUM_BLOCKS-1:0]         present_reg;
    logic [NUM_BLOCKS-1:0]         filled_reg;
    logic [wfba_pkg::SUM_W-1:0]    used_sum_reg;
    logic [wfba_pkg::SUM_W-1:0]    total_sum_reg;

    logic                          found_reg;
    logic [IDX_W-1:0]              best_idx_reg;
    logic [SIZE_BITS-1:0]          best_size_reg;
    logic                          p_vld_reg;
    logic                          p_elig_reg;
    logic [IDX_W-1:0]              p_idx_reg;

    logic                          res_granted_reg;
    logic [wfba_pkg::SLOT_W-1:0]   res_slot_reg;
    logic [wfba_pkg::AMOUNT_W-1:0] res_size_reg;

    logic                          rsp_valid_reg;
    logic                          granted_reg;
    logic [wfba_pkg::SLOT_W-1:0]   chosen_slot_reg;
    logic [wfba_pkg::AMOUNT_W-1:0] chosen_size_reg;
    logic [wfba_pkg::SUM_W-1:0]    used_total_reg;
    logic [wfba_pkg::SUM_W-1:0]    memory_total_reg;

    logic                          ram_re;
    logic [IDX_W-1:0]              ram_raddr;
    logic [SIZE_BITS-1:0]          ram_rdata;

    wfba_pkg::wfba_op_t            alu_op;
    logic [wfba_pkg::SUM_W-1:0]    alu_acc;
    logic [SIZE_BITS-1:0]          alu_operand;
    logic [SIZE_BITS-1:0]          cmp_a;
    logic [wfba_pkg::SUM_W-1:0]    alu_result;
    logic                          alu_greater;
    logic                          take_best;
    logic                          grant;

    assign slot_ok   = 32'(slot) < 32'(NUM_BLOCKS);
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !ctrl.idle;
    assign slot_idx  = IDX_W'(slot_reg);

    wfba_seq #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .kind      (kind),
        .slot_ok   (slot_ok),
        .out_free  (out_free),
        .ctrl      (ctrl),
        .cnt       (cnt)
    );

    assign ram_re    = ctrl.ld_read || ctrl.scan_issue;
    assign ram_raddr = ctrl.scan_issue ? cnt : slot_idx;

    wfba_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (NUM_BLOCKS)
    ) u_sizes (
        .clk   (clk),
        .we    (ctrl.ld_add),
        .waddr (slot_idx),
        .wdata (amount_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // operand steering for the shared unit
    always_comb
    begin
        alu_op      = wfba_pkg::OP_ADD;
        alu_acc     = total_sum_reg;
        alu_operand = amount_reg;
        if (ctrl.ld_sub)
        begin
            alu_op      = wfba_pkg::OP_SUB;
            alu_operand = ram_rdata;
        end
        else if (ctrl.decide)
        begin
            alu_acc = used_sum_reg;
        end
    end

    assign cmp_a = ctrl.decide ? amount_reg : ram_rdata;

    wfba_alu #(
        .SIZE_BITS (SIZE_BITS)
    ) u_alu (
        .op      (alu_op),
        .acc     (alu_acc),
        .operand (alu_operand),
        .cmp_a   (cmp_a),
        .cmp_b   (best_size_reg),
        .result  (alu_result),
        .greater (alu_greater)
    );

    // strict greater keeps the lowest index on a tie
    assign take_best = ctrl.scan_cmp && p_vld_reg && p_elig_reg
                       && (!found_reg || alu_greater);
    assign grant     = ctrl.decide && found_reg && !alu_greater;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg   <= '0;
            filled_reg    <= '0;
            used_sum_reg  <= '0;
            total_sum_reg <= '0;
            found_reg     <= 1'b0;
            p_vld_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.accept)
            begin
                found_reg <= 1'b0;
                p_vld_reg <= 1'b0;
            end
            if (ctrl.ld_sub && present_reg[slot_idx])
            begin
                total_sum_reg <= alu_result;
            end
            if (ctrl.ld_add)
            begin
                total_sum_reg          <= alu_result;
                present_reg[slot_idx]  <= 1'b1;
                filled_reg[slot_idx]   <= 1'b0;
            end
            if (ctrl.scan_cmp)
            begin
                p_vld_reg <= ctrl.scan_issue;
            end
            if (take_best)
            begin
                found_reg <= 1'b1;
            end
            if (grant)
            begin
                filled_reg[best_idx_reg] <= 1'b1;
                used_sum_reg             <= alu_result;
            end
            if (ctrl.emit_go)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            slot_reg        <= slot;
            amount_reg      <= SIZE_BITS'(amount);
            res_granted_reg <= 1'b0;
            res_slot_reg    <= (kind == wfba_pkg::KIND_LOAD) ? slot : '0;
            res_size_reg    <= '0;
        end
        if (ctrl.scan_issue)
        begin
            p_idx_reg  <= cnt;
            p_elig_reg <= present_reg[cnt] && !filled_reg[cnt];
        end
        if (take_best)
        begin
            best_idx_reg  <= p_idx_reg;
            best_size_reg <= ram_rdata;
        end
        if (ctrl.ld_add)
        begin
            res_granted_reg <= 1'b1;
            res_size_reg    <= wfba_pkg::AMOUNT_W'(amount_reg);
        end
        if (grant)
        begin
            res_granted_reg <= 1'b1;
            res_slot_reg    <= wfba_pkg::SLOT_W'(best_idx_reg);
            res_size_reg    <= wfba_pkg::AMOUNT_W'(best_size_reg);
        end
        if (ctrl.emit_go)
        begin
            granted_reg      <= res_granted_reg;
            chosen_slot_reg  <= res_slot_reg;
            chosen_size_reg  <= res_size_reg;
            used_total_reg   <= used_sum_reg;
            memory_total_reg <= total_sum_reg;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign granted      = granted_reg;
    assign chosen_slot  = chosen_slot_reg;
    assign chosen_size  = chosen_size_reg;
    assign used_total   = used_total_reg;
    assign memory_total = memory_total_reg;

    a_rsp_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(ctrl.emit_go))
        else $error("result beat appeared without an emit step");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.accept |=> req_stall)
        else $error("new beat taken while an item is still at work");

    a_best_present: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> present_reg[best_idx_reg])
        else $error("best block is not a present block");

    a_scan_complete: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.decide |-> (p_idx_reg == IDX_W'(NUM_BLOCKS - 1)))
        else $error("decision taken before the scan reached the last block");

    a_used_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        used_sum_reg >= $past(used_sum_reg))
        else $error("used total went down");

endmodule

// ===== sim/tb_worst_fit_block_allocator_unit.sv =====
// tb_worst_fit_block_allocator_unit: self-checking testbench for the worst-fit allocator,
// a directed table followed by random load/allocate traffic under varied idling
// depends on wfba_pkg and worst_fit_block_allocator_unit

module tb_worst_fit_block_allocator_unit;

    localparam int NUM_BLOCKS   = wfba_pkg::DEF_NUM_BLOCKS;
    localparam int RANDOM_BEATS = 1100;
    localparam int PHASE_BEATS  = RANDOM_BEATS / 4;
    localparam int DRAIN_SLACK  = NUM_BLOCKS + 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int NUM_ROWS     = 14;

    typedef struct packed
    {
        logic                          granted;
        logic [wfba_pkg::SLOT_W-1:0]   chosen_slot;
        logic [wfba_pkg::AMOUNT_W-1:0] chosen_size;
        logic [wfba_pkg::SUM_W-1:0]    used_total;
        logic [wfba_pkg::SUM_W-1:0]    memory_total;
    } outcome_t;

    typedef struct packed
    {
        logic                          kind;
        logic [wfba_pkg::SLOT_W-1:0]   slot;
        logic [wfba_pkg::AMOUNT_W-1:0] amount;
        logic                          typed;
        outcome_t                      want;
    } beat_row_t;

    typedef enum logic [1:0]
    {
        PACE_OPEN,
        PACE_SENDER_GAPS,
        PACE_RECEIVER_STALLS,
        PACE_BOTH
    } pace_t;

    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          req_valid    = 1'b0;
    logic                          req_stall;
    logic                          kind         = wfba_pkg::KIND_LOAD;
    logic [wfba_pkg::SLOT_W-1:0]   slot         = '0;
    logic [wfba_pkg::AMOUNT_W-1:0] amount       = '0;
    logic                          rsp_valid;
    logic                          rsp_stall    = 1'b0;
    logic                          granted;
    logic [wfba_pkg::SLOT_W-1:0]   chosen_slot;
    logic [wfba_pkg::AMOUNT_W-1:0] chosen_size;
    logic [wfba_pkg::SUM_W-1:0]    used_total;
    logic [wfba_pkg::SUM_W-1:0]    memory_total;

    // shadow of the allocator table
    logic [wfba_pkg::AMOUNT_W-1:0] shadow_size [NUM_BLOCKS];
    logic                          shadow_present [NUM_BLOCKS];
    logic                          shadow_filled [NUM_BLOCKS];
    logic [wfba_pkg::SUM_W-1:0]    shadow_used;
    logic [wfba_pkg::SUM_W-1:0]    shadow_total;

    outcome_t  pending_outcomes [$];
    beat_row_t directed_rows [NUM_ROWS];

    int unsigned gap_pct      = 0;
    int unsigned stall_pct    = 0;
    int unsigned hold_left    = 0;
    int unsigned cycle_count  = 0;
    int unsigned error_count  = 0;
    int unsigned loads_seen   = 0;
    int unsigned grants_seen  = 0;
    int unsigned refusals_seen = 0;
    int unsigned holdoffs     = 0;

    worst_fit_block_allocator_unit DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .kind         (kind),
        .slot         (slot),
        .amount       (amount),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .granted      (granted),
        .chosen_slot  (chosen_slot),
        .chosen_size  (chosen_size),
        .used_total   (used_total),
        .memory_total (memory_total)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("worst_fit_block_allocator_unit test failed");
            $finish;
        end
    end

    function automatic logic [wfba_pkg::SUM_W-1:0] sum_saturate(
        logic [wfba_pkg::SUM_W-1:0] base, logic [wfba_pkg::AMOUNT_W-1:0] add);
        logic [wfba_pkg::SUM_W:0] s;
        s = {1'b0, base} + add;
        return (s > wfba_pkg::SUM_MAX) ? wfba_pkg::SUM_MAX : s[wfba_pkg::SUM_W-1:0];
    endfunction

    function automatic outcome_t worst_fit_outcome(logic beat_kind,
                                                   logic [wfba_pkg::SLOT_W-1:0] beat_slot,
                                                   logic [wfba_pkg::AMOUNT_W-1:0] beat_amount);
        outcome_t o;
        int       best;
        bit       found;
        o = '0;
        best = 0;
        found = 1'b0;
        if (beat_kind == wfba_pkg::KIND_LOAD)
        begin
            if (beat_slot < NUM_BLOCKS)
            begin
                // reload: retire the old size first, floored at zero
                if (shadow_present[beat_slot])
                    shadow_total = (shadow_size[beat_slot] >= shadow_total) ? '0 :
                                   shadow_total - shadow_size[beat_slot];
                shadow_size[beat_slot]    = beat_amount;
                shadow_present[beat_slot] = 1'b1;
                shadow_filled[beat_slot]  = 1'b0;
                shadow_total = sum_saturate(shadow_total, beat_amount);
                o.granted     = 1'b1;
                o.chosen_size = beat_amount;
            end
            o.chosen_slot = beat_slot;
        end
        else
        begin
            for (int i = 0; i < NUM_BLOCKS; i++)
            begin
                if (shadow_present[i] && !shadow_filled[i] &&
                    (!found || shadow_size[i] > shadow_size[best]))
                begin
                    best  = i;
                    found = 1'b1;
                end
            end
            if (found && beat_amount <= shadow_size[best])
            begin
                shadow_filled[best] = 1'b1;
                shadow_used   = sum_saturate(shadow_used, beat_amount);
                o.granted     = 1'b1;
                o.chosen_slot = best[wfba_pkg::SLOT_W-1:0];
                o.chosen_size = shadow_size[best];
            end
        end
        o.used_total   = shadow_used;
        o.memory_total = shadow_total;
        return o;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        error_count++;
        $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    endtask

    // result side: compare every taken beat with the oldest expectation
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_outcomes.size() == 0)
                report_mismatch("unexpected result beat", 1, 0);
            else
            begin
                want = pending_outcomes.pop_front();
                if (granted !== want.granted)
                    report_mismatch("granted", granted, want.granted);
                if (chosen_slot !== want.chosen_slot)
                    report_mismatch("chosen_slot", chosen_slot, want.chosen_slot);
                if (chosen_size !== want.chosen_size)
                    report_mismatch("chosen_size", chosen_size, want.chosen_size);
                if (used_total !== want.used_total)
                    report_mismatch("used_total", used_total, want.used_total);
                if (memory_total !== want.memory_total)
                    report_mismatch("memory_total", memory_total, want.memory_total);
            end
        end
    end

    // receiver: random stall, or a long hold-off counted down here
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left--;
        end
        else
            rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic offer_beat(input logic beat_kind,
                              input logic [wfba_pkg::SLOT_W-1:0] beat_slot,
                              input logic [wfba_pkg::AMOUNT_W-1:0] beat_amount,
                              input logic typed, input outcome_t want);
        outcome_t predicted;
        while ($urandom_range(99) < gap_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        kind      <= beat_kind;
        slot      <= beat_slot;
        amount    <= beat_amount;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted = worst_fit_outcome(beat_kind, beat_slot, beat_amount);
        if (beat_kind == wfba_pkg::KIND_LOAD)
            loads_seen++;
        else if (predicted.granted)
            grants_seen++;
        else
            refusals_seen++;
        pending_outcomes.push_back(typed ? want : predicted);
    endtask

    task automatic drain_outcomes();
        req_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    initial
    begin
        logic                          rk;
        logic [wfba_pkg::SLOT_W-1:0]   rs;
        logic [wfba_pkg::AMOUNT_W-1:0] ra;
        int unsigned                   pick;
        pace_t                         pace;

        for (int i = 0; i < NUM_BLOCKS; i++)
        begin
            shadow_size[i]    = '0;
            shadow_present[i] = 1'b0;
            shadow_filled[i]  = 1'b0;
        end
        shadow_used  = '0;
        shadow_total = '0;

        // typed rows: empty table, extremes, exhaustion; the rest from the shadow
        directed_rows[0]  = '{wfba_pkg::KIND_ALLOC, 4'd0,  16'd0,    1'b1,
                              '{1'b0, 4'd0,  16'd0,    20'd0,     20'd0}};
        directed_rows[1]  = '{wfba_pkg::KIND_LOAD,  4'd0,  16'hFFFF, 1'b1,
                              '{1'b1, 4'd0,  16'hFFFF, 20'd0,     20'd65535}};
        directed_rows[2]  = '{wfba_pkg::KIND_LOAD,  4'd15, 16'd0,    1'b1,
                              '{1'b1, 4'd15, 16'd0,    20'd0,     20'd65535}};
        directed_rows[3]  = '{wfba_pkg::KIND_ALLOC, 4'd7,  16'hFFFF, 1'b1,
                              '{1'b1, 4'd0,  16'hFFFF, 20'd65535, 20'd65535}};
        directed_rows[4]  = '{wfba_pkg::KIND_ALLOC, 4'd0,  16'd0,    1'b1,
                              '{1'b1, 4'd15, 16'd0,    20'd65535, 20'd65535}};
        directed_rows[5]  = '{wfba_pkg::KIND_ALLOC, 4'd15, 16'd1,    1'b1,
                              '{1'b0, 4'd0,  16'd0,    20'd65535, 20'd65535}};
        directed_rows[6]  = '{wfba_pkg::KIND_LOAD,  4'd0,  16'd100,  1'b0, '0};
        directed_rows[7]  = '{wfba_pkg::KIND_LOAD,  4'd5,  16'd100,  1'b0, '0};
        directed_rows[8]  = '{wfba_pkg::KIND_LOAD,  4'd3,  16'd100,  1'b0, '0};
        directed_rows[9]  = '{wfba_pkg::KIND_ALLOC, 4'd9,  16'd50,   1'b0, '0};
        directed_rows[10] = '{wfba_pkg::KIND_ALLOC, 4'd0,  16'd101,  1'b0, '0};
        directed_rows[11] = '{wfba_pkg::KIND_ALLOC, 4'd0,  16'd100,  1'b0, '0};
        directed_rows[12] = '{wfba_pkg::KIND_LOAD,  4'd15, 16'hFFFF, 1'b0, '0};
        directed_rows[13] = '{wfba_pkg::KIND_LOAD,  4'd10, 16'h5555, 1'b0, '0};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < NUM_ROWS; r++)
            offer_beat(directed_rows[r].kind, directed_rows[r].slot, directed_rows[r].amount,
                       directed_rows[r].typed, directed_rows[r].want);
        drain_outcomes();

        pace = PACE_OPEN;
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n % PHASE_BEATS == 0)
            begin
                drain_outcomes();
                pace = pace_t'(n / PHASE_BEATS);
                case (pace)
                    PACE_OPEN:
                    begin
                        gap_pct   = 0;
                        stall_pct = 0;
                    end
                    PACE_SENDER_GAPS:
                    begin
                        gap_pct   = 49;
                        stall_pct = 0;
                    end
                    PACE_RECEIVER_STALLS:
                    begin
                        gap_pct   = 0;
                        stall_pct = 49;
                    end
                    default:
                    begin
                        gap_pct   = 27;
                        stall_pct = 27;
                    end
                endcase
                // long hold-off while the sender keeps offering
                if (pace == PACE_OPEN || pace == PACE_RECEIVER_STALLS)
                begin
                    hold_left = HOLD_CYCLES;
                    holdoffs++;
                end
            end
            // stretches with no idling inside the idling phases
            if (pace != PACE_OPEN && (n % PHASE_BEATS) >= PHASE_BEATS - 40)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            rk   = ($urandom_range(99) < 45) ? wfba_pkg::KIND_LOAD : wfba_pkg::KIND_ALLOC;
            rs   = wfba_pkg::SLOT_W'($urandom_range(NUM_BLOCKS - 1));
            pick = $urandom_range(11);
            if (pick < 4)
                ra = wfba_pkg::AMOUNT_W'($urandom);
            else if (pick < 8)
                ra = wfba_pkg::AMOUNT_W'($urandom_range(255));
            else if (pick < 10)
                ra = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            else
                ra = 16'hFFFF - wfba_pkg::AMOUNT_W'($urandom_range(3));
            offer_beat(rk, rs, ra, 1'b0, '0);
        end

        drain_outcomes();
        if (pending_outcomes.size() != 0)
            report_mismatch("results left over", pending_outcomes.size(), 0);

        $display("covered %0d loads, %0d grants and %0d refusals over %0d cycles",
                 loads_seen, grants_seen, refusals_seen, cycle_count);
        $display("four pacing phases, %0d long receiver hold-offs, final used total %0d",
                 holdoffs, shadow_used);
        if (error_count == 0)
            $display("worst_fit_block_allocator_unit test passed");
        else
            $display("worst_fit_block_allocator_unit test failed");
        $finish;
    end

endmodule
